### rtl/srr_pkg.sv
package srr_pkg;

  localparam int unsigned WINDOW_SLOTS = 32;
  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5;

  typedef enum logic [2:0] {
    KIND_DELIVER  = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_NACK     = 3'd2,
    KIND_CONFIRM  = 3'd3,
    KIND_BUSY     = 3'd4,
    KIND_SESS_END = 3'd5,
    KIND_DROPPED  = 3'd6
  } srr_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RES,
    ST_DRAIN_RD,
    ST_DRAIN_OUT,
    ST_FINISH,
    ST_END,
    ST_QCONF,
    ST_QSCAN,
    ST_QCMP
  } srr_state_e;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sender_id;
    logic        is_start;
    logic [30:0] seq_index;
    logic [15:0] payload_tag;
    logic [15:0] payload_len;
    logic        short_packet;
  } srr_in_t;

  typedef struct packed {
    srr_kind_e          kind;
    logic        [31:0] dest_sender;
    logic signed [31:0] ack_index;
    logic        [15:0] out_tag;
    logic        [15:0] out_len;
    logic               timed_out;
    logic               last;
  } srr_out_t;

endpackage

### rtl/selective_repeat_receiver.sv
// Selective-repeat receiver.
// Input channel (in_valid_i/in_ready_o, in_data_i): one request per item, either a
// packet arrival or a timer tick. Output channel (out_valid_o/out_ready_i, out_data_o):
// result items; the last one of a request carries last = 1. Requests that give no
// result (sender zero, foreign data, ticks without a session) produce nothing.
// Configuration: cfg_we_i writes cfg_wdata_i into the silence timeout register.
// Timing: one request is worked at a time and is taken only in the idle state. Its first
// result is loaded into the pending-result register and moves on to the output register
// once the output is free. A silent request leaves the block idle; ack, nack, drop,
// confirm and timeout requests end once their result is emitted. An in-order packet
// emits its delivery, then every further buffered slot in turn (slot memory read, then
// emit), then the ack or the session end (walk stop, window advance, emit).
// A start request from another sender while a session runs walks the wait queue, reading
// then comparing each queued entry, and ends with the busy reply. A session end that starts
// a queued sender reads the queue memory and then emits the start confirm.
// The output register decouples the sides: the next request is taken while the
// final result of the previous one still waits for out_ready_i. A stalled receiver
// holds the sequencer on the pending result without loss.
// Reset: no session, empty queue, cleared window valid bits, timeout of 5 ticks.
// Window and queue payloads sit in memories and need no clearing pass.
module selective_repeat_receiver #(
  parameter int unsigned WindowSlots = srr_pkg::WINDOW_SLOTS,
  parameter int unsigned QueueDepth  = srr_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  srr_pkg::srr_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output srr_pkg::srr_out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i
);
  import srr_pkg::*;

  localparam int unsigned PW  = $clog2(WindowSlots);
  localparam int unsigned CW  = $clog2(WindowSlots + 1);
  localparam int unsigned QPW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCW = $clog2(QueueDepth + 1);
  localparam logic [31:0] NO_FINAL = '1;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] len;
  } slot_t;

  typedef struct packed {
    logic [31:0] sender;
    logic [15:0] tag;
  } wait_t;

  function automatic logic [PW-1:0] wrap_w(input logic [PW:0] s);
    logic [PW:0] t;
    t = s - (PW+1)'(WindowSlots);
    return (s >= (PW+1)'(WindowSlots)) ? t[PW-1:0] : s[PW-1:0];
  endfunction

  function automatic logic [QPW-1:0] wrap_q(input logic [QPW:0] s);
    logic [QPW:0] t;
    t = s - (QPW+1)'(QueueDepth);
    return (s >= (QPW+1)'(QueueDepth)) ? t[QPW-1:0] : s[QPW-1:0];
  endfunction

  // Memories
  slot_t slot_mem [WindowSlots];
  wait_t wait_mem [QueueDepth];
  slot_t slot_rd_q;
  wait_t wait_rd_q;

  // Control state
  srr_state_e state_q, state_d;
  logic            out_valid_q;
  srr_out_t        out_q;
  srr_in_t         req_q;
  srr_out_t        res_q, res_d;
  logic            res_load;
  logic [31:0]     cur_q;
  logic [30:0]     exp_q;
  logic [31:0]     final_q;
  logic [WindowSlots-1:0] valid_q;
  logic [PW-1:0]   base_q;
  logic [CW-1:0]   cnt_q;
  logic [QPW-1:0]  head_q;
  logic [QCW-1:0]  count_q;
  logic [QCW-1:0]  scan_q;
  logic [15:0]     idle_q;
  logic            begun_q;
  logic [15:0]     timeout_q;

  // Handshake and emit
  logic     in_fire, out_free, emit_req, emit_fire;
  srr_out_t emit_data;

  // Request decode
  logic          is_tick, sender_zero, cur_match, new_sess, busy_case, data_case;
  logic          seq_eq, seq_lt, off_in;
  logic [30:0]   off;
  logic [PW-1:0] phys_off;
  logic          store_case;
  logic [15:0]   idle_inc;
  logic          tick_end;
  logic [31:0]   exp_m1;

  // Drain and finish
  logic [PW-1:0] drain_phys;
  logic          cnt_lt_w, slot_re;
  logic [31:0]   next32, fin_eff;
  logic          end_cond;

  // Queue
  logic           q_re, q_we, scan_done, q_match;
  logic [QPW-1:0] q_raddr, q_waddr, scan_addr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_fire   = emit_req && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Decode the incoming request against the session state
  assign is_tick     = in_data_i.opcode;
  assign sender_zero = (in_data_i.sender_id == '0);
  assign cur_match   = (in_data_i.sender_id == cur_q);
  assign new_sess    = !cur_match && in_data_i.is_start && (cur_q == '0);
  assign busy_case   = !cur_match && in_data_i.is_start && (cur_q != '0);
  assign data_case   = cur_match && !in_data_i.is_start;
  assign seq_eq      = (in_data_i.seq_index == exp_q);
  assign seq_lt      = (in_data_i.seq_index < exp_q);
  assign off         = in_data_i.seq_index - exp_q;
  assign off_in      = (off < 31'(WindowSlots));
  assign phys_off    = wrap_w({1'b0, base_q} + (PW+1)'(off[PW-1:0]));
  assign store_case  = data_case && !seq_eq && !seq_lt && off_in;
  assign idle_inc    = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign tick_end    = (cur_q != '0) && begun_q && (idle_inc >= timeout_q);
  assign exp_m1      = {1'b0, exp_q} - 32'd1;

  // Window walk
  assign drain_phys = wrap_w({1'b0, base_q} + (PW+1)'(cnt_q));
  assign cnt_lt_w   = (cnt_q < CW'(WindowSlots));
  assign slot_re    = (state_q == ST_DRAIN_RD) && cnt_lt_w && valid_q[drain_phys];
  assign next32     = {1'b0, exp_q} + 32'(cnt_q);
  assign fin_eff    = req_q.short_packet ? {1'b0, req_q.seq_index} : final_q;
  assign end_cond   = (fin_eff != NO_FINAL) && (next32 > fin_eff);

  // Wait queue
  assign scan_done = (scan_q == count_q);
  assign scan_addr = wrap_q({1'b0, head_q} + (QPW+1)'(scan_q));
  assign q_waddr   = wrap_q({1'b0, head_q} + (QPW+1)'(count_q));
  assign q_raddr   = (state_q == ST_END) ? head_q : scan_addr;
  assign q_re      = ((state_q == ST_END) && emit_fire && (count_q != '0)) ||
                     ((state_q == ST_QSCAN) && !scan_done);
  assign q_we      = (state_q == ST_QSCAN) && scan_done &&
                     (count_q < QCW'(QueueDepth));
  assign q_match   = (wait_rd_q.sender == req_q.sender_id);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_tick) begin
            if (tick_end) state_d = ST_END;
          end else if (!sender_zero) begin
            if (busy_case) state_d = ST_QSCAN;
            else if (new_sess || cur_match) state_d = ST_RES;
          end
        end
      end
      ST_RES: begin
        if (emit_fire) state_d = res_q.last ? ST_IDLE : ST_DRAIN_RD;
      end
      ST_DRAIN_RD:  state_d = slot_re ? ST_DRAIN_OUT : ST_FINISH;
      ST_DRAIN_OUT: if (emit_fire) state_d = ST_DRAIN_RD;
      ST_FINISH:    state_d = end_cond ? ST_END : ST_RES;
      ST_END: begin
        if (emit_fire) state_d = (count_q != '0) ? ST_QCONF : ST_IDLE;
      end
      ST_QCONF:     if (emit_fire) state_d = ST_IDLE;
      ST_QSCAN:     state_d = scan_done ? ST_RES : ST_QCMP;
      ST_QCMP:      state_d = q_match ? ST_RES : ST_QSCAN;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Result sourcing
  always_comb begin
    emit_req  = 1'b0;
    emit_data = '0;
    unique case (state_q)
      ST_RES: begin
        emit_req  = 1'b1;
        emit_data = res_q;
      end
      ST_DRAIN_OUT: begin
        emit_req              = 1'b1;
        emit_data.kind        = KIND_DELIVER;
        emit_data.dest_sender = cur_q;
        emit_data.ack_index   = {1'b0, req_q.seq_index + 31'(cnt_q)};
        emit_data.out_tag     = slot_rd_q.tag;
        emit_data.out_len     = slot_rd_q.len;
      end
      ST_END: begin
        emit_req       = 1'b1;
        emit_data      = res_q;
        emit_data.last = (count_q == '0);
      end
      ST_QCONF: begin
        emit_req              = 1'b1;
        emit_data.kind        = KIND_CONFIRM;
        emit_data.dest_sender = wait_rd_q.sender;
        emit_data.out_tag     = wait_rd_q.tag;
        emit_data.last        = 1'b1;
      end
      default: begin
        emit_req  = 1'b0;
        emit_data = '0;
      end
    endcase
  end

  // Prepare the pending result
  always_comb begin
    res_load = 1'b0;
    res_d    = '0;
    priority if (state_q == ST_IDLE && in_fire) begin
      res_load = 1'b1;
      if (is_tick) begin
        res_d.kind        = KIND_SESS_END;
        res_d.dest_sender = cur_q;
        res_d.ack_index   = exp_m1;
        res_d.timed_out   = 1'b1;
      end else if (in_data_i.is_start) begin
        res_d.kind        = KIND_CONFIRM;
        res_d.dest_sender = in_data_i.sender_id;
        res_d.out_tag     = in_data_i.payload_tag;
        res_d.last        = 1'b1;
      end else if (seq_eq) begin
        res_d.kind        = KIND_DELIVER;
        res_d.dest_sender = cur_q;
        res_d.ack_index   = {1'b0, in_data_i.seq_index};
        res_d.out_tag     = in_data_i.payload_tag;
        res_d.out_len     = in_data_i.payload_len;
      end else if (seq_lt) begin
        res_d.kind        = KIND_ACK;
        res_d.dest_sender = cur_q;
        res_d.ack_index   = exp_m1;
        res_d.last        = 1'b1;
      end else begin
        res_d.kind        = off_in ? KIND_NACK : KIND_DROPPED;
        res_d.dest_sender = cur_q;
        res_d.ack_index   = {1'b0, in_data_i.seq_index};
        res_d.last        = 1'b1;
      end
    end else if (state_q == ST_FINISH) begin
      res_load          = 1'b1;
      res_d.kind        = end_cond ? KIND_SESS_END : KIND_ACK;
      res_d.dest_sender = cur_q;
      res_d.ack_index   = end_cond ? next32 - 32'd1 : {1'b0, next32[30:0] - 31'd1};
      res_d.last        = !end_cond;
    end else if ((state_q == ST_QSCAN && scan_done) ||
                 (state_q == ST_QCMP && q_match)) begin
      res_load          = 1'b1;
      res_d.kind        = KIND_BUSY;
      res_d.dest_sender = req_q.sender_id;
      res_d.last        = 1'b1;
    end else begin
      res_load = 1'b0;
    end
  end

  // Window slot memory: write on out-of-order store, read during the walk
  always_ff @(posedge clk_i) begin
    if (in_fire && !is_tick && !sender_zero && store_case && !valid_q[phys_off]) begin
      slot_mem[phys_off] <= '{tag: in_data_i.payload_tag, len: in_data_i.payload_len};
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[drain_phys];
    end
  end

  // Wait queue memory
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      wait_mem[q_waddr] <= '{sender: req_q.sender_id, tag: req_q.payload_tag};
    end
    if (q_re) begin
      wait_rd_q <= wait_mem[q_raddr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= in_data_i;
    if (res_load) res_q <= res_d;
    if (emit_fire) out_q <= emit_data;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      exp_q       <= '0;
      final_q     <= NO_FINAL;
      valid_q     <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      idle_q      <= '0;
      begun_q     <= 1'b0;
      timeout_q   <= TIMEOUT_RESET;
    end else begin
      state_q <= state_d;
      if (emit_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) timeout_q <= cfg_wdata_i;

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_q  <= CW'(1);
            scan_q <= '0;
            if (is_tick) begin
              if (cur_q != '0) idle_q <= idle_inc;
            end else if (!sender_zero) begin
              begun_q <= 1'b1;
              if (new_sess) begin
                // take a fresh session
                cur_q   <= in_data_i.sender_id;
                exp_q   <= '0;
                final_q <= NO_FINAL;
                valid_q <= '0;
                idle_q  <= '0;
              end else if (cur_match) begin
                idle_q <= '0;
                if (store_case) begin
                  valid_q[phys_off] <= 1'b1;
                  if (in_data_i.short_packet) final_q <= {1'b0, in_data_i.seq_index};
                end
              end
            end
          end
        end
        ST_DRAIN_OUT: begin
          if (emit_fire) begin
            valid_q[drain_phys] <= 1'b0;
            cnt_q               <= cnt_q + CW'(1);
          end
        end
        ST_FINISH: begin
          // advance the window by the delivered run
          exp_q   <= next32[30:0];
          base_q  <= wrap_w({1'b0, base_q} + (PW+1)'(cnt_q));
          final_q <= fin_eff;
        end
        ST_END: begin
          if (emit_fire) begin
            exp_q   <= '0;
            final_q <= NO_FINAL;
            valid_q <= '0;
            idle_q  <= '0;
            begun_q <= 1'b0;
            if (count_q == '0) cur_q <= '0;
          end
        end
        ST_QCONF: begin
          if (emit_fire) begin
            cur_q   <= wait_rd_q.sender;
            head_q  <= wrap_q({1'b0, head_q} + (QPW+1)'(1));
            count_q <= count_q - QCW'(1);
          end
        end
        ST_QSCAN: begin
          if (q_we) count_q <= count_q + QCW'(1);
        end
        ST_QCMP: begin
          if (!q_match) scan_q <= scan_q + QCW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QueueDepth))
    else $error("wait queue count beyond depth");

  // Slot at the window base is never occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[base_q])
    else $error("window base slot marked valid");

  // A session end only comes from an active session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_END) |-> (cur_q != '0))
    else $error("session end without a session");

  // A delivery always names a real sender
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_DELIVER) |-> (out_q.dest_sender != '0))
    else $error("delivery to sender zero");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import srr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [31:0] IDX_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] NO_FINAL = 32'hFFFF_FFFF;

  typedef struct {
    srr_in_t  pkt;
    bit       typed;
    srr_out_t want;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  srr_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  srr_out_t out_data_o;
  logic     cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  selective_repeat_receiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted receiver state
  logic [15:0] tmo = TIMEOUT_RESET;
  logic [31:0] cur_sender = '0;
  logic [30:0] exp_idx = '0;
  logic [31:0] fin_idx = NO_FINAL;
  bit          slot_ok [WINDOW_SLOTS];
  logic [15:0] slot_tg [WINDOW_SLOTS];
  logic [15:0] slot_ln [WINDOW_SLOTS];
  logic [31:0] wq_sender [QUEUE_DEPTH];
  logic [15:0] wq_tag [QUEUE_DEPTH];
  int unsigned wq_head = 0;
  int unsigned wq_cnt = 0;
  logic [15:0] idle_cnt = '0;
  bit          begun = 1'b0;

  srr_out_t    replies [$];
  int          errors = 0;
  int unsigned cycles = 0;

  // Stimulus control
  int  p_gap = 0;
  int  p_stall = 0;
  bit  hold = 1'b0;
  bit  row_typed = 1'b0;
  srr_out_t row_want;
  int  burst_k = -1;

  function automatic srr_in_t mk(bit op, logic [31:0] snd, bit st, logic [30:0] seq,
                                 logic [15:0] tg, logic [15:0] ln, bit sh);
    srr_in_t r;
    r.opcode = op; r.sender_id = snd; r.is_start = st; r.seq_index = seq;
    r.payload_tag = tg; r.payload_len = ln; r.short_packet = sh;
    return r;
  endfunction

  function automatic srr_out_t res(srr_kind_e k, logic [31:0] d, logic [31:0] idx,
                                   logic [15:0] tg, logic [15:0] ln, bit to);
    srr_out_t r;
    r.kind = k; r.dest_sender = d; r.ack_index = idx; r.out_tag = tg;
    r.out_len = ln; r.timed_out = to; r.last = 1'b0;
    return r;
  endfunction

  task automatic put(srr_kind_e k, logic [31:0] d, logic [31:0] idx,
                     logic [15:0] tg, logic [15:0] ln, bit to);
    replies.push_back(res(k, d, idx, tg, ln, to));
  endtask

  task automatic wipe_session();
    exp_idx = '0;
    fin_idx = NO_FINAL;
    foreach (slot_ok[k]) slot_ok[k] = 1'b0;
    idle_cnt = '0;
    begun = 1'b0;
  endtask

  // End the served session and promote the oldest waiting sender, if any.
  task automatic close_session(logic [31:0] idx, bit to);
    put(KIND_SESS_END, cur_sender, idx, '0, '0, to);
    wipe_session();
    if (wq_cnt > 0) begin
      cur_sender = wq_sender[wq_head];
      put(KIND_CONFIRM, cur_sender, '0, wq_tag[wq_head], '0, 1'b0);
      wq_head = (wq_head + 1) % QUEUE_DEPTH;
      wq_cnt--;
    end else begin
      cur_sender = '0;
    end
  endtask

  task automatic take_data(srr_in_t it);
    logic [31:0] seq, nxt, off;
    int unsigned cnt;
    seq = {1'b0, it.seq_index};
    if (it.seq_index == exp_idx) begin
      put(KIND_DELIVER, cur_sender, seq, it.payload_tag, it.payload_len, 1'b0);
      cnt = 1;
      while (cnt < WINDOW_SLOTS && slot_ok[cnt]) begin
        put(KIND_DELIVER, cur_sender, (seq + cnt) & IDX_MASK, slot_tg[cnt], slot_ln[cnt], 1'b0);
        cnt++;
      end
      // slide the window by the delivered run
      for (int k = 0; k < WINDOW_SLOTS; k++) begin
        if (k + cnt < WINDOW_SLOTS) begin
          slot_ok[k] = slot_ok[k + cnt];
          slot_tg[k] = slot_tg[k + cnt];
          slot_ln[k] = slot_ln[k + cnt];
        end else begin
          slot_ok[k] = 1'b0;
        end
      end
      nxt = {1'b0, exp_idx} + cnt;
      exp_idx = nxt[30:0];
      if (it.short_packet) fin_idx = seq;
      if (fin_idx != NO_FINAL && nxt > fin_idx) close_session(nxt - 1, 1'b0);
      else put(KIND_ACK, cur_sender, (nxt - 1) & IDX_MASK, '0, '0, 1'b0);
    end else if (it.seq_index < exp_idx) begin
      put(KIND_ACK, cur_sender, {1'b0, exp_idx} - 1, '0, '0, 1'b0);
    end else begin
      off = seq - {1'b0, exp_idx};
      if (off >= WINDOW_SLOTS) begin
        put(KIND_DROPPED, cur_sender, seq, '0, '0, 1'b0);
      end else begin
        if (!slot_ok[off]) begin
          slot_ok[off] = 1'b1;
          slot_tg[off] = it.payload_tag;
          slot_ln[off] = it.payload_len;
        end
        put(KIND_NACK, cur_sender, seq, '0, '0, 1'b0);
        if (it.short_packet) fin_idx = seq;
      end
    end
  endtask

  task automatic park_sender(logic [31:0] snd, logic [15:0] tg);
    int unsigned slot;
    for (int unsigned i = 0; i < wq_cnt; i++)
      if (wq_sender[(wq_head + i) % QUEUE_DEPTH] == snd) return;
    if (wq_cnt >= QUEUE_DEPTH) return;
    slot = (wq_head + wq_cnt) % QUEUE_DEPTH;
    wq_sender[slot] = snd;
    wq_tag[slot] = tg;
    wq_cnt++;
  endtask

  // Work out the replies one accepted request causes.
  task automatic predict_replies(srr_in_t it);
    int n0;
    srr_out_t tail;
    n0 = replies.size();
    if (it.opcode) begin
      if (cur_sender != 0) begin
        if (idle_cnt != 16'hFFFF) idle_cnt++;
        if (begun && idle_cnt >= tmo) close_session({1'b0, exp_idx} - 1, 1'b1);
      end
    end else if (it.sender_id != 0) begin
      begun = 1'b1;
      if (it.sender_id != cur_sender && !it.is_start) begin
        // foreign data: drop silently
      end else if (it.sender_id != cur_sender && cur_sender != 0) begin
        park_sender(it.sender_id, it.payload_tag);
        put(KIND_BUSY, it.sender_id, '0, '0, '0, 1'b0);
      end else begin
        if (it.sender_id != cur_sender) begin
          cur_sender = it.sender_id;
          wipe_session();
          begun = 1'b1;
        end
        idle_cnt = '0;
        if (it.is_start) put(KIND_CONFIRM, cur_sender, '0, it.payload_tag, '0, 1'b0);
        else take_data(it);
      end
    end
    if (replies.size() > n0) begin
      tail = replies.pop_back();
      tail.last = 1'b1;
      replies.push_back(tail);
    end
  endtask

  // Sample both channels and the register port at the rising edge.
  always @(posedge clk_i) begin
    srr_out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL selective_repeat_receiver");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_we_i) tmo = cfg_wdata_i;
      if (out_valid_o && out_ready_i) begin
        if (replies.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected reply %p", out_data_o);
        end else begin
          want = replies.pop_front();
          if (out_data_o.kind !== want.kind || out_data_o.dest_sender !== want.dest_sender ||
              out_data_o.ack_index !== want.ack_index || out_data_o.out_tag !== want.out_tag ||
              out_data_o.out_len !== want.out_len || out_data_o.timed_out !== want.timed_out ||
              out_data_o.last !== want.last) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, out_data_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_replies(in_data_i);
        // typed rows carry exactly one reply: use the hand-written value
        if (row_typed) begin
          void'(replies.pop_back());
          replies.push_back(row_want);
        end
      end
    end
  end

  // Receiver side: random stall, or a long hold-off while the block fills up.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && !hold && ($urandom_range(99) >= p_stall);
  end

  // Offer one request; called at a falling edge, returns at a falling edge.
  task automatic offer(srr_in_t it, bit typed, srr_out_t want);
    while ($urandom_range(99) < p_gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    row_typed = typed;
    row_want = want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold the sender until every reply is back, then let the block settle.
  task automatic settle();
    in_valid_i <= 1'b0;
    row_typed = 1'b0;
    while (replies.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_sender();
    if ($urandom_range(9) == 0) return $urandom() | 32'h1;
    return 32'($urandom_range(20, 1));
  endfunction

  // Mostly well-formed traffic for the served sender, plus noise.
  function automatic srr_in_t next_request();
    int unsigned r;
    logic [31:0] off;
    logic [30:0] seq;
    bit sh;
    r = $urandom_range(99);
    if (burst_k >= 0 && cur_sender != 0) begin
      // fill the whole window from the top, then release it in one drain
      seq = exp_idx + 31'(burst_k);
      burst_k--;
      return mk(1'b0, cur_sender, 1'b0, seq, 16'($urandom()), 16'($urandom()), 1'b0);
    end
    burst_k = -1;
    if (r < 8) return mk(1'b1, $urandom(), 1'($urandom_range(1)), 31'($urandom()),
                         16'($urandom()), 16'($urandom()), 1'($urandom_range(1)));
    if (r < 11) return mk(1'b0, '0, 1'($urandom_range(1)), 31'($urandom()),
                          16'($urandom()), 16'($urandom()), 1'($urandom_range(1)));
    if (r < 15) return mk(1'b0, pick_sender(), 1'b0, 31'($urandom()), 16'($urandom()),
                          16'($urandom()), 1'($urandom_range(1)));
    if (cur_sender == 0 || r < 27)
      return mk(1'b0, pick_sender(), 1'b1, 31'($urandom()), 16'($urandom()),
                16'($urandom()), 1'b0);
    if (r < 30) begin
      burst_k = 31;
      return mk(1'b0, cur_sender, 1'b1, '0, 16'($urandom()), '0, 1'b0);
    end
    r = $urandom_range(99);
    if (r < 40) off = 0;
    else if (r < 75) off = $urandom_range(10, 1);
    else if (r < 85) off = $urandom_range(31, 11);
    else if (r < 92) off = $urandom_range(63, 32);
    else off = $urandom();
    seq = exp_idx + off[30:0];
    if (r >= 95 && exp_idx != 0) seq = 31'($urandom_range(exp_idx - 1));
    sh = ($urandom_range(99) < 6);
    return mk(1'b0, cur_sender, 1'b0, seq, 16'($urandom()), 16'($urandom()), sh);
  endfunction

  initial begin
    stim_row_t rows [$];
    srr_out_t none;
    int gaps [4] = '{0, 51, 0, 37};
    int stalls [4] = '{0, 0, 51, 37};
    logic [15:0] timeouts [4] = '{16'hFFFF, 16'd1, 16'd3, 16'd2};
    none = '0;

    // Directed rows: session start, queueing, window edges, completion, timeout.
    rows.push_back('{mk(1, 32'd7, 0, 0, 0, 0, 0), 0, none});          // tick without session
    rows.push_back('{mk(0, 32'd0, 1, 5, 16'h1111, 0, 0), 0, none});   // sender zero
    rows.push_back('{mk(0, 32'd7, 0, 0, 16'h2222, 1, 0), 0, none});   // data with no session
    rows.push_back('{mk(0, 32'd7, 1, 0, 16'hABCD, 0, 0), 1,
                     res(KIND_CONFIRM, 32'd7, 0, 16'hABCD, 0, 0) | 1});
    rows.push_back('{mk(0, 32'd7, 1, 0, 16'h0000, 0, 0), 0, none});   // repeated start
    rows.push_back('{mk(0, 32'd9, 1, 0, 16'h1234, 0, 0), 1,
                     res(KIND_BUSY, 32'd9, 0, 0, 0, 0) | 1});
    rows.push_back('{mk(0, 32'd9, 1, 0, 16'h5678, 0, 0), 0, none});   // duplicate wait
    rows.push_back('{mk(0, 32'd7, 0, 2, 16'h0002, 16'd20, 0), 1,
                     res(KIND_NACK, 32'd7, 2, 0, 0, 0) | 1});
    rows.push_back('{mk(0, 32'd7, 0, 1, 16'hFFFF, 16'hFFFF, 0), 0, none});
    rows.push_back('{mk(0, 32'd7, 0, 40, 16'h0040, 0, 0), 1,
                     res(KIND_DROPPED, 32'd7, 40, 0, 0, 0) | 1});
    rows.push_back('{mk(0, 32'd7, 0, 31'h7FFF_FFFF, 0, 0, 1), 1,
                     res(KIND_DROPPED, 32'd7, 32'h7FFF_FFFF, 0, 0, 0) | 1});
    rows.push_back('{mk(0, 32'd7, 0, 0, 16'h0000, 16'h0000, 0), 0, none});
    rows.push_back('{mk(0, 32'd7, 0, 1, 16'h0101, 16'd3, 0), 1,
                     res(KIND_ACK, 32'd7, 2, 0, 0, 0) | 1});
    rows.push_back('{mk(0, 32'd7, 0, 34, 16'h0034, 16'd9, 0), 0, none}); // top window slot
    rows.push_back('{mk(0, 32'd9, 0, 3, 16'h0909, 16'd9, 0), 0, none});  // foreign data
    rows.push_back('{mk(0, 32'd7, 0, 4, 16'h0404, 16'd4, 1), 0, none});  // final, ahead
    rows.push_back('{mk(0, 32'd7, 0, 3, 16'h0303, 16'd3, 0), 0, none});  // completion
    rows.push_back('{mk(0, 32'd9, 0, 5, 16'h0505, 16'd5, 0), 0, none});
    repeat (4) rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0), 1,
                     res(KIND_SESS_END, 32'd9, 32'hFFFF_FFFF, 0, 0, 1) | 1});
    rows.push_back('{mk(1, 32'hFFFF_FFFF, 1, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 1), 0, none});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) offer(rows[i].pkt, rows[i].typed, rows[i].want);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      p_gap = gaps[ph];
      p_stall = stalls[ph];
      write_timeout(timeouts[ph]);
      if (ph == 0) begin
        fork
          begin
            hold = 1'b1;
            repeat (400) @(negedge clk_i);
            hold = 1'b0;
          end
        join_none
      end
      repeat (72) offer(next_request(), 1'b0, none);
      settle();
    end

    if (errors == 0 && replies.size() == 0) begin
      $display("PASS selective_repeat_receiver");
    end else begin
      $display("FAIL selective_repeat_receiver");
    end
    $finish;
  end

endmodule

### files.f
rtl/srr_pkg.sv
rtl/selective_repeat_receiver.sv
tb/sv/testbench.sv
